// ===== hdl/lav_pkg.sv =====
`timescale 1ns / 1ps

package lav_pkg;

  localparam int POS_W    = 32;
  localparam int DIR_W    = 16;
  localparam int DIR_FRAC = DIR_W - 2;
  localparam int IFRAC    = 16;
  localparam int FSH      = IFRAC - DIR_FRAC;
  localparam int LEN_EXT  = 10;
  // internal direction width, holds the projected up vector before scaling
  localparam int VW       = 20;
  localparam int SQ_N     = VW + LEN_EXT;
  localparam int DIV_N    = IFRAC + 1;
  localparam int NORM_LAT = SQ_N + DIV_N + 4;
  localparam longint unsigned EPS_SQ = (64'd1 << (2 * IFRAC)) / 64'd100000000;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Z = 2'd2;
  localparam logic signed [DIR_W-1:0] UP_Y_RST = DIR_W'(1 << DIR_FRAC);
  localparam int DIR_MAX = 2 ** (DIR_W - 1) - 1;
  localparam int DIR_MIN = -(2 ** (DIR_W - 1));

  typedef logic signed [VW-1:0] comp_t;
  typedef comp_t [2:0] vec_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef pos_t [2:0] pos3_t;

  typedef struct packed {
    logic signed [POS_W-1:0] eye_x;
    logic signed [POS_W-1:0] eye_y;
    logic signed [POS_W-1:0] eye_z;
    logic signed [DIR_W-1:0] look_x;
    logic signed [DIR_W-1:0] look_y;
    logic signed [DIR_W-1:0] look_z;
  } in_word_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] right_x;
    logic signed [DIR_W-1:0] right_y;
    logic signed [DIR_W-1:0] right_z;
    logic signed [DIR_W-1:0] upaxis_x;
    logic signed [DIR_W-1:0] upaxis_y;
    logic signed [DIR_W-1:0] upaxis_z;
    logic signed [DIR_W-1:0] fwd_x;
    logic signed [DIR_W-1:0] fwd_y;
    logic signed [DIR_W-1:0] fwd_z;
    logic signed [POS_W-1:0] trans_x;
    logic signed [POS_W-1:0] trans_y;
    logic signed [POS_W-1:0] trans_z;
  } out_word_t;

  // internal q.16 back to field format, round half up, saturate
  function automatic logic signed [DIR_W-1:0] dir_out(comp_t v);
    logic signed [VW:0] t;
    t = (VW + 1)'(v);
    t = (t + (VW + 1)'(1 << (FSH - 1))) >>> FSH;
    if (t > (VW + 1)'(DIR_MAX)) begin
      return DIR_W'(DIR_MAX);
    end else if (t < (VW + 1)'(DIR_MIN)) begin
      return DIR_W'(DIR_MIN);
    end
    return DIR_W'(t);
  endfunction

endpackage

// ===== hdl/look_at_view_matrix.sv =====
`timescale 1ns / 1ps

// Look-at view transform, one camera pose per word in, one view word out.
// Fully pipelined: a new pose is taken every cycle unless the output buffer
// is full. Most of the pipeline depth lies in the two vector normalizers,
// each a 30-stage square root (one root bit per stage) followed by a
// 17-stage divider (one quotient bit per stage). A two-entry output buffer
// lets one more word enter while a result is held; after that the whole
// pipeline holds until it drains.
// The up vector registers must only be written while no pose is in flight.
module look_at_view_matrix (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  lav_pkg::in_word_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output lav_pkg::out_word_t                 out_data,
  input  logic                               cfg_we,
  input  logic [lav_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [lav_pkg::DIR_W-1:0]          cfg_wdata
);

  localparam int NL = lav_pkg::NORM_LAT;
  localparam int DW = lav_pkg::DIR_W;
  localparam int PW = lav_pkg::POS_W;
  localparam int VW = lav_pkg::VW;

  logic signed [DW-1:0] up_x_r, up_y_r, up_z_r;
  lav_pkg::comp_t       upi [3];

  logic en;

  logic                 s0_v_r;
  lav_pkg::pos3_t       s0_eye_r;
  lav_pkg::vec_t        s0_f_r;

  logic                 n1_v;
  lav_pkg::vec_t        n1_f;
  lav_pkg::pos3_t       eye1_r [NL];

  logic                 p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  lav_pkg::pos3_t       p1_eye_r, p2_eye_r, p3_eye_r, p4_eye_r;
  lav_pkg::vec_t        p1_f_r, p2_f_r, p3_f_r, p4_f_r;
  logic signed [2*VW-1:0] p1_prod_r [3];
  logic signed [23:0]   p2_a_r;
  logic signed [43:0]   p3_af_r [3];
  lav_pkg::vec_t        p4_u_r;
  logic signed [2*VW+1:0] dot_sum;

  logic                 n2_v;
  lav_pkg::vec_t        n2_u;
  lav_pkg::pos3_t       eye2_r [NL];
  lav_pkg::vec_t        f2_r   [NL];

  logic                 c1_v_r, c2_v_r;
  lav_pkg::pos3_t       c1_eye_r, c2_eye_r;
  lav_pkg::vec_t        c1_f_r, c2_f_r, c1_u_r, c2_u_r, c2_r_r;
  logic signed [2*VW-1:0] c1_cp_r [6];
  logic signed [2*VW:0] cdiff [3];

  lav_pkg::comp_t       ax [9];
  logic                 t1_v_r, t2_v_r;
  logic signed [DW-1:0] t1_d_r [9];
  logic signed [DW-1:0] t2_d_r [9];
  logic signed [PW+VW-1:0] t1_p_r [9];
  logic signed [PW+VW+1:0] tsum [3];
  logic signed [37:0]   t2_t_r [3];
  logic signed [38:0]   tneg [3];
  logic signed [PW-1:0] tsat [3];

  logic                 lst_v_r;
  lav_pkg::out_word_t   lst_r;
  logic                 out_v_r, skid_v_r;
  lav_pkg::out_word_t   out_r, skid_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_x_r <= '0;
      up_y_r <= lav_pkg::UP_Y_RST;
      up_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lav_pkg::CFG_UP_X: up_x_r <= cfg_wdata;
        lav_pkg::CFG_UP_Y: up_y_r <= cfg_wdata;
        lav_pkg::CFG_UP_Z: up_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    upi[0] = lav_pkg::comp_t'(up_x_r) <<< lav_pkg::FSH;
    upi[1] = lav_pkg::comp_t'(up_y_r) <<< lav_pkg::FSH;
    upi[2] = lav_pkg::comp_t'(up_z_r) <<< lav_pkg::FSH;
  end

  // pipeline holds only while the output buffer is full
  assign en       = !skid_v_r;
  assign in_ready = en;

  lav_norm u_norm_f (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_v_r),
    .in_vec    (s0_f_r),
    .out_valid (n1_v),
    .out_vec   (n1_f)
  );

  lav_norm u_norm_u (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p4_v_r),
    .in_vec    (p4_u_r),
    .out_valid (n2_v),
    .out_vec   (n2_u)
  );

  assign dot_sum = (2*VW+2)'(p1_prod_r[0]) + (2*VW+2)'(p1_prod_r[1])
                 + (2*VW+2)'(p1_prod_r[2]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cdiff[i] = (2*VW+1)'(c1_cp_r[2*i]) - (2*VW+1)'(c1_cp_r[2*i+1]);
    end
    for (int i = 0; i < 3; i++) begin
      ax[i]     = c2_r_r[i];
      ax[3 + i] = c2_u_r[i];
      ax[6 + i] = c2_f_r[i];
    end
    for (int j = 0; j < 3; j++) begin
      tsum[j] = (PW+VW+2)'(t1_p_r[3*j]) + (PW+VW+2)'(t1_p_r[3*j+1])
              + (PW+VW+2)'(t1_p_r[3*j+2]);
      tneg[j] = -(39'(t2_t_r[j]));
      if (tneg[j] > ((39'sd1 <<< (PW - 1)) - 39'sd1)) begin
        tsat[j] = {1'b0, {(PW - 1){1'b1}}};
      end else if (tneg[j] < -(39'sd1 <<< (PW - 1))) begin
        tsat[j] = {1'b1, {(PW - 1){1'b0}}};
      end else begin
        tsat[j] = PW'(tneg[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      p3_v_r  <= 1'b0;
      p4_v_r  <= 1'b0;
      c1_v_r  <= 1'b0;
      c2_v_r  <= 1'b0;
      t1_v_r  <= 1'b0;
      t2_v_r  <= 1'b0;
      lst_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r  <= in_valid;
      p1_v_r  <= n1_v;
      p2_v_r  <= p1_v_r;
      p3_v_r  <= p2_v_r;
      p4_v_r  <= p3_v_r;
      c1_v_r  <= n2_v;
      c2_v_r  <= c1_v_r;
      t1_v_r  <= c2_v_r;
      t2_v_r  <= t1_v_r;
      lst_v_r <= t2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_eye_r[0] <= in_data.eye_x;
      s0_eye_r[1] <= in_data.eye_y;
      s0_eye_r[2] <= in_data.eye_z;
      s0_f_r[0]   <= lav_pkg::comp_t'($signed(in_data.look_x)) <<< lav_pkg::FSH;
      s0_f_r[1]   <= lav_pkg::comp_t'($signed(in_data.look_y)) <<< lav_pkg::FSH;
      s0_f_r[2]   <= lav_pkg::comp_t'($signed(in_data.look_z)) <<< lav_pkg::FSH;

      eye1_r[0] <= s0_eye_r;
      eye2_r[0] <= p4_eye_r;
      f2_r[0]   <= p4_f_r;
      for (int k = 1; k < NL; k++) begin
        eye1_r[k] <= eye1_r[k-1];
        eye2_r[k] <= eye2_r[k-1];
        f2_r[k]   <= f2_r[k-1];
      end

      // project up onto forward and remove that part
      p1_eye_r <= eye1_r[NL-1];
      p1_f_r   <= n1_f;
      for (int i = 0; i < 3; i++) begin
        p1_prod_r[i] <= n1_f[i] * upi[i];
      end

      p2_eye_r <= p1_eye_r;
      p2_f_r   <= p1_f_r;
      p2_a_r   <= 24'((dot_sum + (2*VW+2)'(32768)) >>> lav_pkg::IFRAC);

      p3_eye_r <= p2_eye_r;
      p3_f_r   <= p2_f_r;
      for (int i = 0; i < 3; i++) begin
        p3_af_r[i] <= p2_a_r * p2_f_r[i];
      end

      p4_eye_r <= p3_eye_r;
      p4_f_r   <= p3_f_r;
      for (int i = 0; i < 3; i++) begin
        p4_u_r[i] <= upi[i] - VW'((p3_af_r[i] + 44'sd32768) >>> lav_pkg::IFRAC);
      end

      // right = up x forward
      c1_eye_r   <= eye2_r[NL-1];
      c1_f_r     <= f2_r[NL-1];
      c1_u_r     <= n2_u;
      c1_cp_r[0] <= n2_u[1] * f2_r[NL-1][2];
      c1_cp_r[1] <= n2_u[2] * f2_r[NL-1][1];
      c1_cp_r[2] <= n2_u[2] * f2_r[NL-1][0];
      c1_cp_r[3] <= n2_u[0] * f2_r[NL-1][2];
      c1_cp_r[4] <= n2_u[0] * f2_r[NL-1][1];
      c1_cp_r[5] <= n2_u[1] * f2_r[NL-1][0];

      c2_eye_r <= c1_eye_r;
      c2_f_r   <= c1_f_r;
      c2_u_r   <= c1_u_r;
      for (int i = 0; i < 3; i++) begin
        c2_r_r[i] <= VW'((cdiff[i] + (2*VW+1)'(32768)) >>> lav_pkg::IFRAC);
      end

      // translation is the negated exact dot product, rounded once and saturated
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          t1_p_r[3*j+i] <= c2_eye_r[i] * ax[3*j+i];
        end
      end
      for (int k = 0; k < 9; k++) begin
        t1_d_r[k] <= lav_pkg::dir_out(ax[k]);
      end

      t2_d_r <= t1_d_r;
      for (int j = 0; j < 3; j++) begin
        t2_t_r[j] <= 38'((tsum[j] + (PW+VW+2)'(32768)) >>> lav_pkg::IFRAC);
      end

      lst_r.right_x  <= t2_d_r[0];
      lst_r.right_y  <= t2_d_r[1];
      lst_r.right_z  <= t2_d_r[2];
      lst_r.upaxis_x <= t2_d_r[3];
      lst_r.upaxis_y <= t2_d_r[4];
      lst_r.upaxis_z <= t2_d_r[5];
      lst_r.fwd_x    <= t2_d_r[6];
      lst_r.fwd_y    <= t2_d_r[7];
      lst_r.fwd_z    <= t2_d_r[8];
      lst_r.trans_x  <= tsat[0];
      lst_r.trans_y  <= tsat[1];
      lst_r.trans_z  <= tsat[2];
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (lst_v_r) begin
      if (!out_v_r || out_ready) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        out_r <= skid_r;
      end
    end else if (lst_v_r) begin
      if (!out_v_r || out_ready) begin
        out_r <= lst_r;
      end else begin
        skid_r <= lst_r;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held without an output word");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready && lst_v_r && !skid_v_r) |=> skid_v_r)
    else $error("word leaving the pipeline was not caught by the skid entry");

  a_hold_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_ready) |=> (skid_v_r && $stable(lst_v_r) && $stable(s0_v_r)))
    else $error("pipeline moved while the output buffer was full");

endmodule

// ===== hdl/lav_norm.sv =====
`timescale 1ns / 1ps

module lav_norm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  lav_pkg::vec_t in_vec,
  output logic          out_valid,
  output lav_pkg::vec_t out_vec
);

  localparam int VW = lav_pkg::VW;
  localparam int SW = 2 * VW;
  localparam int LW = lav_pkg::SQ_N;
  localparam int XW = 2 * LW;
  localparam int RW = LW + 3;
  localparam int DN = lav_pkg::DIV_N;
  localparam int SH = lav_pkg::IFRAC + lav_pkg::LEN_EXT;
  localparam int NW = VW + SH;

  // one root bit per stage
  function automatic logic [RW+LW-1:0] sq_step(logic [RW-1:0] rem, logic [LW-1:0] root,
                                               logic [1:0] b);
    logic [RW-1:0] rn;
    logic [RW-1:0] tr;
    rn = {rem[RW-3:0], b};
    tr = RW'({root, 2'b01});
    if (rn >= tr) begin
      return {rn - tr, root[LW-2:0], 1'b1};
    end
    return {rn, root[LW-2:0], 1'b0};
  endfunction

  // one quotient bit per stage, restoring
  function automatic logic [LW:0] dv_step(logic [LW-1:0] rem, logic [LW-1:0] len, logic b);
    logic [LW:0] r2;
    r2 = {rem, b};
    if (r2 >= {1'b0, len}) begin
      return {LW'(r2 - {1'b0, len}), 1'b1};
    end
    return {r2[LW-1:0], 1'b0};
  endfunction

  logic                 sq_v_r;
  lav_pkg::vec_t        sq_vec_r;
  logic signed [SW-1:0] sq_sq_r [3];

  logic                 sm_v_r;
  lav_pkg::vec_t        sm_vec_r;
  logic                 sm_short_r;
  logic [XW-1:0]        sm_x_r;
  logic [SW-1:0]        sum;

  logic                 rt_v_r     [LW];
  lav_pkg::vec_t        rt_vec_r   [LW];
  logic                 rt_short_r [LW];
  logic [RW-1:0]        rt_rem_r   [LW];
  logic [LW-1:0]        rt_root_r  [LW];
  logic [XW-1:0]        rt_x_r     [LW];

  logic                 pp_v_r;
  lav_pkg::vec_t        pp_vec_r;
  logic                 pp_short_r;
  logic [LW-1:0]        pp_len_r;
  logic [LW-1:0]        pp_rem_r [3];
  logic [DN-1:0]        pp_low_r [3];
  logic [VW-1:0]        mag      [3];
  logic [NW-1:0]        num      [3];

  logic                 dv_v_r     [DN];
  lav_pkg::vec_t        dv_vec_r   [DN];
  logic                 dv_short_r [DN];
  logic [LW-1:0]        dv_len_r   [DN];
  logic [LW-1:0]        dv_rem_r   [DN][3];
  logic [DN-1:0]        dv_low_r   [DN][3];
  logic [DN-1:0]        dv_q_r     [DN][3];

  logic                 out_v_r;
  lav_pkg::vec_t        out_r;

  assign sum = SW'(sq_sq_r[0]) + SW'(sq_sq_r[1]) + SW'(sq_sq_r[2]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = rt_vec_r[LW-1][i][VW-1] ? VW'(-rt_vec_r[LW-1][i]) : VW'(rt_vec_r[LW-1][i]);
      num[i] = {mag[i], {SH{1'b0}}} + NW'(rt_root_r[LW-1] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r  <= 1'b0;
      sm_v_r  <= 1'b0;
      pp_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k < LW; k++) begin
        rt_v_r[k] <= 1'b0;
      end
      for (int k = 0; k < DN; k++) begin
        dv_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      sq_v_r    <= in_valid;
      sm_v_r    <= sq_v_r;
      rt_v_r[0] <= sm_v_r;
      for (int k = 1; k < LW; k++) begin
        rt_v_r[k] <= rt_v_r[k-1];
      end
      pp_v_r    <= rt_v_r[LW-1];
      dv_v_r[0] <= pp_v_r;
      for (int k = 1; k < DN; k++) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
      out_v_r   <= dv_v_r[DN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_vec_r <= in_vec;
      for (int i = 0; i < 3; i++) begin
        sq_sq_r[i] <= in_vec[i] * in_vec[i];
      end

      sm_vec_r   <= sq_vec_r;
      sm_short_r <= (sum <= SW'(lav_pkg::EPS_SQ));
      sm_x_r     <= {sum, {(XW - SW){1'b0}}};

      rt_vec_r[0]   <= sm_vec_r;
      rt_short_r[0] <= sm_short_r;
      {rt_rem_r[0], rt_root_r[0]} <= sq_step('0, '0, sm_x_r[XW-1:XW-2]);
      rt_x_r[0]     <= sm_x_r << 2;
      for (int k = 1; k < LW; k++) begin
        rt_vec_r[k]   <= rt_vec_r[k-1];
        rt_short_r[k] <= rt_short_r[k-1];
        {rt_rem_r[k], rt_root_r[k]} <= sq_step(rt_rem_r[k-1], rt_root_r[k-1],
                                               rt_x_r[k-1][XW-1:XW-2]);
        rt_x_r[k]     <= rt_x_r[k-1] << 2;
      end

      pp_vec_r   <= rt_vec_r[LW-1];
      pp_short_r <= rt_short_r[LW-1];
      pp_len_r   <= rt_root_r[LW-1];
      for (int i = 0; i < 3; i++) begin
        pp_rem_r[i] <= LW'(num[i][NW-1:DN]);
        pp_low_r[i] <= num[i][DN-1:0];
      end

      dv_vec_r[0]   <= pp_vec_r;
      dv_short_r[0] <= pp_short_r;
      dv_len_r[0]   <= pp_len_r;
      for (int i = 0; i < 3; i++) begin
        {dv_rem_r[0][i], dv_q_r[0][i][0]} <= dv_step(pp_rem_r[i], pp_len_r,
                                                     pp_low_r[i][DN-1]);
        dv_q_r[0][i][DN-1:1] <= '0;
        dv_low_r[0][i]       <= pp_low_r[i] << 1;
      end
      for (int k = 1; k < DN; k++) begin
        dv_vec_r[k]   <= dv_vec_r[k-1];
        dv_short_r[k] <= dv_short_r[k-1];
        dv_len_r[k]   <= dv_len_r[k-1];
        for (int i = 0; i < 3; i++) begin
          {dv_rem_r[k][i], dv_q_r[k][i][0]} <= dv_step(dv_rem_r[k-1][i], dv_len_r[k-1],
                                                       dv_low_r[k-1][i][DN-1]);
          dv_q_r[k][i][DN-1:1] <= dv_q_r[k-1][i][DN-2:0];
          dv_low_r[k][i]       <= dv_low_r[k-1][i] << 1;
        end
      end

      for (int i = 0; i < 3; i++) begin
        // short vectors pass through unscaled
        if (dv_short_r[DN-1]) begin
          out_r[i] <= dv_vec_r[DN-1][i];
        end else if (dv_vec_r[DN-1][i][VW-1]) begin
          out_r[i] <= -lav_pkg::comp_t'(dv_q_r[DN-1][i]);
        end else begin
          out_r[i] <= lav_pkg::comp_t'(dv_q_r[DN-1][i]);
        end
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_vec   = out_r;

endmodule
